// ===== sv/mfrc_pkg.sv =====
// Shared types, constants and codes of the message fragment reassembly checker.
`timescale 1ns / 1ps
`default_nettype none

package mfrc_pkg;

   // Fragment and header sizes in bytes
   localparam int unsigned FRAGMENT_BYTES = 4096;
   localparam int unsigned HEADER_BYTES   = 48;

   // Depth of the queue between front and back
   localparam int unsigned QUEUE_DEPTH = 2;
   localparam int unsigned QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int unsigned QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   // Stream widths, padded to whole bytes
   localparam int unsigned REQ_BITS   = 226;
   localparam int unsigned REQ_TDATA_W = ((REQ_BITS + 7) / 8) * 8;
   localparam int unsigned RSP_BITS   = 142;
   localparam int unsigned RSP_TDATA_W = ((RSP_BITS + 7) / 8) * 8;

   // Configuration register indexes
   localparam logic CSR_CONG_FLAG = 1'b0;
   localparam logic CSR_ACK_MASK  = 1'b1;

   // Configuration reset values
   localparam logic [7:0] CONG_FLAG_RESET = 8'd1;
   localparam logic [7:0] ACK_MASK_RESET  = 8'd2;

   // Outcome codes
   localparam logic [2:0] OUT_STORED    = 3'd0;
   localparam logic [2:0] OUT_DELIVERED = 3'd1;
   localparam logic [2:0] OUT_CONG_MAP  = 3'd2;
   localparam logic [2:0] OUT_PURE_ACK  = 3'd3;
   localparam logic [2:0] OUT_SHORT     = 3'd4;
   localparam logic [2:0] OUT_CHECKSUM  = 3'd5;
   localparam logic [2:0] OUT_MISMATCH  = 3'd6;
   localparam logic [2:0] OUT_FAILED    = 3'd7;

   // Classification made by the front
   typedef enum logic [2:0] {
      KIND_FAILED,
      KIND_SHORT,
      KIND_CHECKSUM,
      KIND_PURE_ACK,
      KIND_DATA
   } kind_type;

   // One receive completion as it arrives
   typedef struct packed {
      logic        completion_ok;
      logic [15:0] byte_count;
      logic        checksum_ok;
      logic [63:0] hdr_sequence;
      logic [63:0] hdr_ack;
      logic [31:0] hdr_length;
      logic [15:0] hdr_source_port;
      logic [15:0] hdr_dest_port;
      logic [7:0]  hdr_flag_bits;
      logic [7:0]  hdr_credit;
   } req_item_type;

   // Classified completion handed to the back
   typedef struct packed {
      kind_type    kind;
      logic [63:0] sequence_num;
      logic [63:0] ack_num;
      logic [31:0] length;
      logic [15:0] source_port;
      logic [15:0] dest_port;
      logic [7:0]  flag_bits;
      logic [7:0]  credit;
   } work_item_type;

   // One result
   typedef struct packed {
      logic [2:0]  outcome;
      logic [7:0]  credits_to_add;
      logic        deliver_sequence_valid;
      logic [63:0] deliver_sequence;
      logic        ack_required_out;
      logic        peer_acked_valid;
      logic [63:0] peer_acked_sequence;
   } result_type;

endpackage

`default_nettype wire

// ===== sv/mfrc_front.sv =====
// Front stage: registers each completion and classifies it before the queue.
`timescale 1ns / 1ps
`default_nettype none

module mfrc_front
   import mfrc_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          in_valid,
   output logic               in_ready,
   input  wire req_item_type  in_item,
   output logic               out_valid,
   input  wire logic          out_ready,
   output work_item_type      out_item
);

   logic          valid_ff;
   logic          valid_in;
   work_item_type item_ff;
   work_item_type item_in;
   kind_type      kind;
   logic          no_payload;

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_item  = item_ff;

   // Classification in check order
   always_comb begin
      no_payload = (in_item.byte_count == 16'(HEADER_BYTES));
      if (!in_item.completion_ok) begin
         kind = KIND_FAILED;
      end else if (in_item.byte_count < 16'(HEADER_BYTES)) begin
         kind = KIND_SHORT;
      end else if (!in_item.checksum_ok) begin
         kind = KIND_CHECKSUM;
      end else if (in_item.hdr_source_port == 16'd0 && in_item.hdr_dest_port == 16'd0
                   && no_payload) begin
         kind = KIND_PURE_ACK;
      end else begin
         kind = KIND_DATA;
      end
   end

   always_comb begin
      item_in              = item_ff;
      valid_in             = valid_ff;
      if (in_valid && in_ready) begin
         item_in.kind         = kind;
         item_in.sequence_num = in_item.hdr_sequence;
         item_in.ack_num      = in_item.hdr_ack;
         item_in.length       = in_item.hdr_length;
         item_in.source_port  = in_item.hdr_source_port;
         item_in.dest_port    = in_item.hdr_dest_port;
         item_in.flag_bits    = in_item.hdr_flag_bits;
         item_in.credit       = in_item.hdr_credit;
         valid_in             = 1'b1;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

endmodule

`default_nettype wire

// ===== sv/mfrc_queue.sv =====
// Short queue of classified completions between front and back.
`timescale 1ns / 1ps
`default_nettype none

module mfrc_queue
   import mfrc_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          push_valid,
   output logic               push_ready,
   input  wire work_item_type push_item,
   output logic               pop_valid,
   input  wire logic          pop_ready,
   output work_item_type      pop_item
);

   work_item_type              entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]     wr_ptr_ff;
   logic [QUEUE_PTR_W-1:0]     wr_ptr_in;
   logic [QUEUE_PTR_W-1:0]     rd_ptr_ff;
   logic [QUEUE_PTR_W-1:0]     rd_ptr_in;
   logic [QUEUE_CNT_W-1:0]     count_ff;
   logic [QUEUE_CNT_W-1:0]     count_in;
   logic                       do_push;
   logic                       do_pop;

   // Push only when not full, so no path runs from the back to the front
   assign push_ready = (count_ff != QUEUE_CNT_W'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_item   = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   // Pointer and fill count updates
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                  : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                  : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

`default_nettype wire

// ===== sv/mfrc_back.sv =====
// Back stage: reassembly state, header checks, peer ack tracking and result register.
`timescale 1ns / 1ps
`default_nettype none

module mfrc_back
   import mfrc_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          csr_wr_en,
   input  wire logic          csr_index,
   input  wire logic [7:0]    csr_wdata,
   input  wire logic          in_valid,
   output logic               in_ready,
   input  wire work_item_type in_item,
   output logic               out_valid,
   input  wire logic          out_ready,
   output result_type         out_result
);

   // Configuration
   logic [7:0]  cong_flag_ff;
   logic [7:0]  ack_mask_ff;

   // Reassembly state
   logic        in_prog_ff;
   logic        in_prog_in;
   logic [63:0] held_seq_ff;
   logic [31:0] held_len_ff;
   logic [15:0] held_sport_ff;
   logic [15:0] held_dport_ff;
   logic [7:0]  held_flags_ff;
   logic        latch_hdr;
   logic [31:0] remaining_ff;
   logic [31:0] remaining_in;
   logic [63:0] highest_ack_ff;
   logic [63:0] highest_ack_in;

   // Result register
   logic        out_valid_ff;
   logic        out_valid_in;
   result_type  result_ff;
   result_type  result_in;

   logic        take;
   logic        accepted_kind;
   logic        mismatch;
   logic [63:0] cur_seq;
   logic [7:0]  cur_flags;
   logic [31:0] cur_remaining;
   logic        more_expected;

   assign in_ready   = !out_valid_ff || out_ready;
   assign take       = in_valid && in_ready;
   assign out_valid  = out_valid_ff;
   assign out_result = result_ff;

   // Per-item evaluation against the current state
   always_comb begin
      accepted_kind = (in_item.kind == KIND_PURE_ACK) || (in_item.kind == KIND_DATA);
      mismatch      = in_prog_ff && ((held_seq_ff != in_item.sequence_num)
                      || (held_len_ff != in_item.length)
                      || (held_sport_ff != in_item.source_port)
                      || (held_dport_ff != in_item.dest_port));
      cur_seq       = in_prog_ff ? held_seq_ff   : in_item.sequence_num;
      cur_flags     = in_prog_ff ? held_flags_ff : in_item.flag_bits;
      cur_remaining = in_prog_ff ? remaining_ff  : in_item.length;
      more_expected = (cur_remaining > 32'(FRAGMENT_BYTES));

      result_in      = '0;
      in_prog_in     = in_prog_ff;
      remaining_in   = remaining_ff;
      highest_ack_in = highest_ack_ff;
      latch_hdr      = 1'b0;

      // Credits and peer ack apply to every item past the checksum
      if (accepted_kind) begin
         result_in.credits_to_add = in_item.credit;
         if (in_item.ack_num > highest_ack_ff) begin
            highest_ack_in                = in_item.ack_num;
            result_in.peer_acked_valid    = 1'b1;
            result_in.peer_acked_sequence = in_item.ack_num;
         end
      end

      case (in_item.kind)
         KIND_FAILED:   result_in.outcome = OUT_FAILED;
         KIND_SHORT:    result_in.outcome = OUT_SHORT;
         KIND_CHECKSUM: result_in.outcome = OUT_CHECKSUM;
         KIND_PURE_ACK: result_in.outcome = OUT_PURE_ACK;
         KIND_DATA: begin
            if (mismatch) begin
               result_in.outcome = OUT_MISMATCH;
            end else begin
               latch_hdr = !in_prog_ff;
               if (more_expected) begin
                  result_in.outcome = OUT_STORED;
                  in_prog_in        = 1'b1;
                  remaining_in      = cur_remaining - 32'(FRAGMENT_BYTES);
               end else begin
                  in_prog_in   = 1'b0;
                  remaining_in = '0;
                  if (cur_flags == cong_flag_ff) begin
                     result_in.outcome = OUT_CONG_MAP;
                  end else begin
                     result_in.outcome                = OUT_DELIVERED;
                     result_in.deliver_sequence_valid = 1'b1;
                     result_in.deliver_sequence       = cur_seq;
                  end
                  result_in.ack_required_out = ((cur_flags & ack_mask_ff) != 8'd0);
               end
            end
         end
         default: result_in.outcome = OUT_FAILED;
      endcase

      if (take) begin
         out_valid_in = 1'b1;
      end else if (out_ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   // Control state and configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         cong_flag_ff   <= CONG_FLAG_RESET;
         ack_mask_ff    <= ACK_MASK_RESET;
         in_prog_ff     <= 1'b0;
         remaining_ff   <= '0;
         highest_ack_ff <= '0;
         out_valid_ff   <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_CONG_FLAG: cong_flag_ff <= csr_wdata;
               CSR_ACK_MASK:  ack_mask_ff  <= csr_wdata;
               default:       ;
            endcase
         end
         if (take) begin
            in_prog_ff     <= in_prog_in;
            remaining_ff   <= remaining_in;
            highest_ack_ff <= highest_ack_in;
         end
         out_valid_ff <= out_valid_in;
      end
   end

   // Held header and result payload
   always_ff @(posedge clock) begin
      if (take && latch_hdr) begin
         held_seq_ff   <= in_item.sequence_num;
         held_len_ff   <= in_item.length;
         held_sport_ff <= in_item.source_port;
         held_dport_ff <= in_item.dest_port;
         held_flags_ff <= in_item.flag_bits;
      end
      if (take) begin
         result_ff <= result_in;
      end
   end

   // Remaining count is only nonzero while a message is open
   a_remaining_idle: assert property (@(posedge clock) disable iff (reset)
      !in_prog_ff |-> remaining_ff == 32'd0)
      else $error("remaining bytes nonzero with no message in progress");

   // Highest peer ack never moves backward
   a_ack_monotonic: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> highest_ack_ff >= $past(highest_ack_ff))
      else $error("highest peer ack decreased");

   // A completed message closes reassembly
   a_complete_closes: assert property (@(posedge clock) disable iff (reset)
      take && in_item.kind == KIND_DATA && !mismatch && !more_expected
      |=> !in_prog_ff)
      else $error("message still open after completion");

   // Delivery sequence only accompanies a delivered outcome
   a_deliver_outcome: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && result_ff.deliver_sequence_valid
      |-> result_ff.outcome == OUT_DELIVERED)
      else $error("delivery sequence with wrong outcome");

endmodule

`default_nettype wire

// ===== sv/message_fragment_reassembly_checker_unit.sv =====
// Top level of the message fragment reassembly checker.
//
// Usage: receive completions arrive on the req_ stream, one per transfer,
// each carrying the success flag, byte count, checksum verdict and header
// fields. Every completion produces exactly one result transfer on the rsp_
// stream: the outcome code, credits to grant, the delivered sequence, the
// ack-required flag and any newly acknowledged peer sequence.
// A req_ transfer reaches rsp_tvalid through the front register, then a queue
// entry, then the result register of the back stage. Throughput is one
// completion per cycle while rsp_tready does not hold the result, set by the
// back stage that updates the reassembly state once per cycle.
// When rsp_tready is low the result holds, the queue takes two more
// completions, the front register one more, and then req_tready drops;
// nothing is lost or duplicated.
// Synchronous reset empties all stages, closes any message in progress,
// clears the highest peer ack and loads the configuration defaults.
// The csr_ port writes the register selected by csr_index; write only while idle.
`timescale 1ns / 1ps
`default_nettype none

module message_fragment_reassembly_checker_unit
   import mfrc_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   // Configuration writes
   input  wire logic                   csr_wr_en,
   input  wire logic                   csr_index,
   input  wire logic [7:0]             csr_wdata,
   // Completion stream
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   // completion_ok, byte_count, checksum_ok, hdr_sequence, hdr_ack, hdr_length,
   // hdr_source_port, hdr_dest_port, hdr_flag_bits, hdr_credit, zero pad
   input  wire logic [REQ_TDATA_W-1:0] req_tdata,
   // Result stream
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   // outcome, credits_to_add, deliver_sequence_valid, deliver_sequence,
   // ack_required_out, peer_acked_valid, peer_acked_sequence, zero pad
   output logic [RSP_TDATA_W-1:0]      rsp_tdata
);

   req_item_type  req_item;
   work_item_type front_item;
   work_item_type queue_item;
   logic          front_valid;
   logic          front_ready;
   logic          queue_valid;
   logic          queue_ready;
   result_type    result;

   // Unpack completion fields
   always_comb begin
      req_item.completion_ok   = req_tdata[0];
      req_item.byte_count      = req_tdata[16:1];
      req_item.checksum_ok     = req_tdata[17];
      req_item.hdr_sequence    = req_tdata[81:18];
      req_item.hdr_ack         = req_tdata[145:82];
      req_item.hdr_length      = req_tdata[177:146];
      req_item.hdr_source_port = req_tdata[193:178];
      req_item.hdr_dest_port   = req_tdata[209:194];
      req_item.hdr_flag_bits   = req_tdata[217:210];
      req_item.hdr_credit      = req_tdata[225:218];
   end

   mfrc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_item   (req_item),
      .out_valid (front_valid),
      .out_ready (front_ready),
      .out_item  (front_item)
   );

   mfrc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (front_valid),
      .push_ready (front_ready),
      .push_item  (front_item),
      .pop_valid  (queue_valid),
      .pop_ready  (queue_ready),
      .pop_item   (queue_item)
   );

   mfrc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .in_valid   (queue_valid),
      .in_ready   (queue_ready),
      .in_item    (queue_item),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_result (result)
   );

   // Pack result fields
   always_comb begin
      rsp_tdata          = '0;
      rsp_tdata[2:0]     = result.outcome;
      rsp_tdata[10:3]    = result.credits_to_add;
      rsp_tdata[11]      = result.deliver_sequence_valid;
      rsp_tdata[75:12]   = result.deliver_sequence;
      rsp_tdata[76]      = result.ack_required_out;
      rsp_tdata[77]      = result.peer_acked_valid;
      rsp_tdata[141:78]  = result.peer_acked_sequence;
   end

endmodule

`default_nettype wire

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the message fragment reassembly checker unit.
`timescale 1ns / 1ps
`default_nettype none

module testbench
   import mfrc_pkg::*;
();

   // Completion fields, most significant first so the packed layout matches req_tdata
   typedef struct packed {
      logic [7:0]  credit;
      logic [7:0]  flag_bits;
      logic [15:0] dest_port;
      logic [15:0] source_port;
      logic [31:0] length;
      logic [63:0] ack_num;
      logic [63:0] seq_num;
      logic        checksum_ok;
      logic [15:0] byte_count;
      logic        completion_ok;
   } rx_completion_type;

   // Result fields, most significant first so the packed layout matches rsp_tdata
   typedef struct packed {
      logic [63:0] peer_acked_sequence;
      logic        peer_acked_valid;
      logic        ack_needed;
      logic [63:0] deliver_sequence;
      logic        deliver_valid;
      logic [7:0]  credits;
      logic [2:0]  outcome;
   } verdict_type;

   // One row of the directed table; typed rows carry their own expected verdict
   typedef struct packed {
      logic              typed;
      verdict_type       want;
      rx_completion_type item;
   } directed_row_type;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   csr_wr_en;
   logic                   csr_index;
   logic [7:0]             csr_wdata;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [RSP_TDATA_W-1:0] rsp_tdata;

   message_fragment_reassembly_checker_unit dut (
      .clock      (clock),
      .reset      (reset),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #5 clock = ~clock;

   // Reassembly state and register copies kept by the predictor
   logic [7:0]  cfg_cong_flags;
   logic [7:0]  cfg_ack_mask;
   logic        asm_open;
   logic [63:0] asm_seq;
   logic [31:0] asm_len;
   logic [15:0] asm_sport;
   logic [15:0] asm_dport;
   logic [7:0]  asm_flags;
   logic [31:0] asm_left;
   logic [63:0] peer_ack_high;

   verdict_type expected_verdicts[$];
   int          mismatches = 0;
   logic        no_idle = 1'b0;

   // Classify one completion and advance the reassembly state
   function automatic verdict_type classify_completion(input rx_completion_type c);
      verdict_type v;
      v = '0;
      if (!c.completion_ok) begin
         v.outcome = OUT_FAILED;
         return v;
      end
      if (32'(c.byte_count) < HEADER_BYTES) begin
         v.outcome = OUT_SHORT;
         return v;
      end
      if (!c.checksum_ok) begin
         v.outcome = OUT_CHECKSUM;
         return v;
      end
      v.credits = c.credit;
      if (c.ack_num > peer_ack_high) begin
         peer_ack_high = c.ack_num;
         v.peer_acked_valid = 1'b1;
         v.peer_acked_sequence = c.ack_num;
      end
      // header only, no ports: acknowledgement without data
      if (c.source_port == '0 && c.dest_port == '0 && 32'(c.byte_count) == HEADER_BYTES) begin
         v.outcome = OUT_PURE_ACK;
         return v;
      end
      if (!asm_open) begin
         asm_open  = 1'b1;
         asm_seq   = c.seq_num;
         asm_len   = c.length;
         asm_sport = c.source_port;
         asm_dport = c.dest_port;
         asm_flags = c.flag_bits;
         asm_left  = c.length;
      end else if (asm_seq != c.seq_num || asm_len != c.length ||
                   asm_sport != c.source_port || asm_dport != c.dest_port) begin
         v.outcome = OUT_MISMATCH;
         return v;
      end
      if (asm_left > FRAGMENT_BYTES) begin
         asm_left = asm_left - FRAGMENT_BYTES;
         v.outcome = OUT_STORED;
         return v;
      end
      // last fragment closes the message
      asm_left = '0;
      asm_open = 1'b0;
      if (asm_flags == cfg_cong_flags) begin
         v.outcome = OUT_CONG_MAP;
      end else begin
         v.outcome = OUT_DELIVERED;
         v.deliver_valid = 1'b1;
         v.deliver_sequence = asm_seq;
      end
      v.ack_needed = |(asm_flags & cfg_ack_mask);
      return v;
   endfunction

   function automatic rx_completion_type completion(
      input logic ok, input logic [15:0] count, input logic csum,
      input logic [63:0] seq, input logic [63:0] ack, input logic [31:0] len,
      input logic [15:0] sport, input logic [15:0] dport,
      input logic [7:0] flags, input logic [7:0] credit);
      rx_completion_type c;
      c.completion_ok = ok;
      c.byte_count    = count;
      c.checksum_ok   = csum;
      c.seq_num       = seq;
      c.ack_num       = ack;
      c.length        = len;
      c.source_port   = sport;
      c.dest_port     = dport;
      c.flag_bits     = flags;
      c.credit        = credit;
      return c;
   endfunction

   function automatic verdict_type verdict(
      input logic [2:0] outcome, input logic [7:0] credits, input logic dv,
      input logic [63:0] dseq, input logic ack_req, input logic pav,
      input logic [63:0] pas);
      verdict_type v;
      v.outcome             = outcome;
      v.credits             = credits;
      v.deliver_valid       = dv;
      v.deliver_sequence    = dseq;
      v.ack_needed          = ack_req;
      v.peer_acked_valid    = pav;
      v.peer_acked_sequence = pas;
      return v;
   endfunction

   function automatic string describe(input verdict_type v);
      return $sformatf("outcome %0d credits %0d deliver %0b/%h ack_req %0b peer %0b/%h",
                       v.outcome, v.credits, v.deliver_valid, v.deliver_sequence,
                       v.ack_needed, v.peer_acked_valid, v.peer_acked_sequence);
   endfunction

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // Peer ack: mostly just above the highest seen, sometimes behind it, rarely anywhere
   function automatic logic [63:0] pick_ack();
      case ($urandom_range(0, 19))
         0:       return rand64();
         1, 2, 3: return peer_ack_high - 64'($urandom_range(0, 1000));
         default: return peer_ack_high + 64'($urandom_range(0, 3));
      endcase
   endfunction

   // Message lengths cluster around whole fragments
   function automatic logic [31:0] pick_length();
      case ($urandom_range(0, 5))
         0:       return '0;
         1:       return 32'(FRAGMENT_BYTES * $urandom_range(1, 4));
         2:       return 32'(FRAGMENT_BYTES * $urandom_range(1, 4) + 1);
         3:       return 32'(FRAGMENT_BYTES * $urandom_range(1, 4) - 1);
         default: return 32'($urandom_range(1, 5 * FRAGMENT_BYTES));
      endcase
   endfunction

   // Next good fragment of a message; flags only matter on the first one
   function automatic rx_completion_type fragment_of(input rx_completion_type hdr);
      rx_completion_type c;
      c = hdr;
      c.completion_ok = 1'b1;
      c.checksum_ok   = 1'b1;
      if ($urandom_range(0, 9) == 0)
         c.byte_count = 16'($urandom_range(HEADER_BYTES + 1, 65535));
      else
         c.byte_count = 16'(HEADER_BYTES + $urandom_range(1, FRAGMENT_BYTES));
      c.ack_num = pick_ack();
      c.credit  = 8'($urandom);
      if (asm_open)
         c.flag_bits = 8'($urandom);
      return c;
   endfunction

   // Error, pure ack or off-header completion mixed into the message stream
   function automatic rx_completion_type noise_completion();
      rx_completion_type c;
      c = completion(1'b1, 16'($urandom), 1'b1, rand64(), pick_ack(), $urandom,
                     16'($urandom), 16'($urandom), 8'($urandom), 8'($urandom));
      case ($urandom_range(0, 4))
         0: begin
            c.completion_ok = 1'b0;
            c.checksum_ok = 1'($urandom);
         end
         1: c.byte_count = 16'($urandom_range(0, HEADER_BYTES - 1));
         2: begin
            c.checksum_ok = 1'b0;
            c.byte_count = 16'($urandom_range(HEADER_BYTES, 65535));
         end
         3: begin
            c.byte_count = 16'(HEADER_BYTES);
            c.source_port = '0;
            c.dest_port = '0;
         end
         default: begin
            c.byte_count = 16'($urandom_range(HEADER_BYTES, 65535));
            if (asm_open) begin
               // held header with one bit flipped in one compared field
               c.seq_num = asm_seq;
               c.length = asm_len;
               c.source_port = asm_sport;
               c.dest_port = asm_dport;
               case ($urandom_range(0, 3))
                  0: c.seq_num = c.seq_num ^ (64'(1) << $urandom_range(0, 63));
                  1: c.length = c.length ^ (32'(1) << $urandom_range(0, 31));
                  2: c.source_port = c.source_port ^ (16'(1) << $urandom_range(0, 15));
                  default: c.dest_port = c.dest_port ^ (16'(1) << $urandom_range(0, 15));
               endcase
            end else begin
               c.byte_count = 16'(HEADER_BYTES);
               c.source_port = '0;
               c.dest_port = '0;
            end
         end
      endcase
      return c;
   endfunction

   // Offer one completion, wait for its transfer, then record what it should produce
   task automatic push_completion(input rx_completion_type c, input logic typed,
                                  input verdict_type want);
      verdict_type v;
      if (!no_idle && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {{(REQ_TDATA_W - $bits(rx_completion_type)){1'b0}}, c};
      do @(posedge clock); while (!req_tready);
      v = classify_completion(c);
      expected_verdicts.push_back(typed ? want : v);
   endtask

   // Stop offering and wait until every outstanding result is back
   task automatic settle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (expected_verdicts.size() != 0) @(posedge clock);
   endtask

   task automatic set_config(input logic [7:0] cong_flags, input logic [7:0] ack_mask);
      csr_wr_en <= 1'b1;
      csr_index <= CSR_CONG_FLAG;
      csr_wdata <= cong_flags;
      @(posedge clock);
      csr_index <= CSR_ACK_MASK;
      csr_wdata <= ack_mask;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      cfg_cong_flags = cong_flags;
      cfg_ack_mask = ack_mask;
   endtask

   // Result side: random stalls, with long stretches of steady ready
   initial begin
      rsp_tready <= 1'b0;
      @(posedge clock);
      forever begin
         rsp_tready <= 1'b1;
         repeat (($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 40)) @(posedge clock);
         if (!no_idle && $urandom_range(0, 1) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clock);
         end
      end
   end

   // Compare each result transfer with the oldest expectation
   always @(posedge clock) begin : check_results
      verdict_type got;
      verdict_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = verdict_type'(rsp_tdata[$bits(verdict_type)-1:0]);
         if (expected_verdicts.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: result with none expected: %s", $time, describe(got));
         end else begin
            want = expected_verdicts.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("%0t: expected %s", $time, describe(want));
                  $display("%0t: received %s", $time, describe(got));
               end
            end
         end
      end
   end

   initial begin : stimulus
      directed_row_type  rows[$];
      rx_completion_type hdr;
      int                phase_items;

      reset      <= 1'b1;
      csr_wr_en  <= 1'b0;
      csr_index  <= CSR_CONG_FLAG;
      csr_wdata  <= '0;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      cfg_cong_flags = CONG_FLAG_RESET;
      cfg_ack_mask   = ACK_MASK_RESET;
      asm_open  = 1'b0;
      asm_seq   = '0;
      asm_len   = '0;
      asm_sport = '0;
      asm_dport = '0;
      asm_flags = '0;
      asm_left  = '0;
      peer_ack_high = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed: errors, pure acks, one-fragment messages, mismatches, multi-fragment
      rows.push_back('{1'b1, verdict(OUT_FAILED, '0, '0, '0, '0, '0, '0),
         completion(1'b0, 16'hFFFF, 1'b1, '1, '1, '1, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF)});
      rows.push_back('{1'b1, verdict(OUT_SHORT, '0, '0, '0, '0, '0, '0),
         completion(1'b1, 16'd47, 1'b1, '1, '1, '1, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF)});
      rows.push_back('{1'b1, verdict(OUT_SHORT, '0, '0, '0, '0, '0, '0),
         completion(1'b1, 16'd0, 1'b0, '0, '0, '0, '0, '0, '0, '0)});
      rows.push_back('{1'b1, verdict(OUT_CHECKSUM, '0, '0, '0, '0, '0, '0),
         completion(1'b1, 16'hFFFF, 1'b0, '1, '1, '1, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF)});
      rows.push_back('{1'b1, verdict(OUT_PURE_ACK, 8'hFF, '0, '0, '0, 1'b1, 64'd5),
         completion(1'b1, 16'd48, 1'b1, '1, 64'd5, '1, '0, '0, 8'hFF, 8'hFF)});
      rows.push_back('{1'b1, verdict(OUT_PURE_ACK, '0, '0, '0, '0, '0, '0),
         completion(1'b1, 16'd48, 1'b1, '0, '0, '0, '0, '0, '0, '0)});
      rows.push_back('{1'b1, verdict(OUT_DELIVERED, 8'd1, 1'b1, '1, 1'b0, 1'b0, '0),
         completion(1'b1, 16'd48, 1'b1, '1, 64'd5, '0, 16'd1, '0, 8'h00, 8'd1)});
      rows.push_back('{1'b1, verdict(OUT_CONG_MAP, 8'h80, '0, '0, 1'b0, 1'b1, 64'd6),
         completion(1'b1, 16'hFFFF, 1'b1, 64'd7, 64'd6, 32'd4096, '0, 16'hFFFF,
                    8'h01, 8'h80)});
      rows.push_back('{1'b0, '0, completion(1'b1, 16'd1000, 1'b1, 64'h0123_4567_89AB_CDEF,
         64'd7, 32'd4097, 16'h1234, 16'h5678, 8'hFF, 8'd3)});
      rows.push_back('{1'b0, '0, completion(1'b1, 16'd1000, 1'b1, 64'h0123_4567_89AB_CDEF,
         64'd8, 32'd4097, 16'h1235, 16'h5678, 8'hFF, 8'd4)});
      rows.push_back('{1'b0, '0, completion(1'b1, 16'd1000, 1'b1, 64'h0123_4567_89AB_CDEF,
         64'd8, 32'd4097, 16'h1234, 16'hD678, 8'hFF, 8'd5)});
      rows.push_back('{1'b0, '0, completion(1'b1, 16'd1000, 1'b1, 64'h8123_4567_89AB_CDEF,
         64'd9, 32'd4097, 16'h1234, 16'h5678, 8'hFF, 8'd6)});
      rows.push_back('{1'b0, '0, completion(1'b1, 16'd1000, 1'b1, 64'h0123_4567_89AB_CDEF,
         64'd9, 32'hFFFF_FFFF, 16'h1234, 16'h5678, 8'hFF, 8'd7)});
      rows.push_back('{1'b0, '0, completion(1'b1, 16'd48, 1'b1, 64'd0,
         64'd1000, 32'd0, '0, '0, 8'h00, 8'd8)});
      rows.push_back('{1'b0, '0, completion(1'b1, 16'd20, 1'b1, 64'h0123_4567_89AB_CDEF,
         64'd2000, 32'd4097, 16'h1234, 16'h5678, 8'hFF, 8'd9)});
      rows.push_back('{1'b0, '0, completion(1'b1, 16'd49, 1'b1, 64'h0123_4567_89AB_CDEF,
         64'd1001, 32'd4097, 16'h1234, 16'h5678, 8'h00, 8'd10)});
      rows.push_back('{1'b0, '0, completion(1'b1, 16'd49, 1'b1, 64'd42,
         64'd1001, 32'd0, '0, '0, 8'h02, 8'd11)});
      rows.push_back('{1'b0, '0, completion(1'b1, 16'd4144, 1'b1, 64'd43,
         64'd1002, 32'd8192, 16'd80, 16'd443, 8'h01, 8'd12)});
      rows.push_back('{1'b0, '0, completion(1'b1, 16'd4144, 1'b1, 64'd43,
         64'd1003, 32'd8192, 16'd80, 16'd443, 8'h01, 8'd13)});
      rows.push_back('{1'b0, '0, completion(1'b1, 16'd4143, 1'b1, 64'd44,
         64'd1003, 32'd4095, 16'd81, 16'd444, 8'h03, 8'd14)});
      foreach (rows[i])
         push_completion(rows[i].item, rows[i].typed, rows[i].want);

      // Random: well-formed messages with noise between fragments, one register set per phase
      for (int phase = 0; phase < 4; phase++) begin
         if (phase > 0) begin
            settle();
            case (phase)
               1:       set_config(8'h00, 8'h00);
               2:       set_config(8'hFF, 8'hFF);
               default: set_config(8'($urandom), 8'($urandom));
            endcase
         end
         phase_items = 0;
         while (phase_items < 330) begin
            hdr = completion(1'b1, '0, 1'b1, rand64(), '0, pick_length(),
                             16'($urandom), 16'($urandom), '0, '0);
            case ($urandom_range(0, 4))
               0:       hdr.flag_bits = cfg_cong_flags;
               1:       hdr.flag_bits = 8'h00;
               2:       hdr.flag_bits = 8'hFF;
               default: hdr.flag_bits = 8'($urandom);
            endcase
            do begin
               if ($urandom_range(0, 3) == 0) begin
                  push_completion(noise_completion(), 1'b0, '0);
                  phase_items++;
               end
               push_completion(fragment_of(hdr), 1'b0, '0);
               phase_items++;
               // no idling on either side over the tail of the run
               if (phase == 3 && phase_items >= 150)
                  no_idle = 1'b1;
            end while (asm_open);
         end
      end

      // Largest possible peer ack, left to the end since it can never be exceeded
      push_completion(completion(1'b1, 16'(HEADER_BYTES), 1'b1, '0, '1, '0, '0, '0, '0,
                                 8'hFF), 1'b0, '0);

      settle();
      repeat (8) @(posedge clock);
      if (mismatches == 0 && expected_verdicts.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   // Run limit, far beyond the slowest legal run
   initial begin
      #5_000_000;
      $display("Mismatches found");
      $finish;
   end

endmodule

`default_nettype wire
